// File: design/pcm_peak_to_peak_envelope_unit_defines.svh
// Assertion macros shared by the envelope unit RTL.
// Each macro expects clk and rst_n to be visible in the calling module.
`ifndef PCM_PEAK_TO_PEAK_ENVELOPE_UNIT_DEFINES_SVH
`define PCM_PEAK_TO_PEAK_ENVELOPE_UNIT_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define PPE_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PPE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/ppe_pkg.sv
// Package for the PCM peak-to-peak envelope unit: widths, register codes,
// bundle types and the amplitude threshold tables. No dependencies.
`timescale 1ns / 1ps

package ppe_pkg;

    localparam int WINDOWS_PER_SECOND = 60;
    localparam int MIN_RATE = (WINDOWS_PER_SECOND > 60) ? WINDOWS_PER_SECOND : 60;

    localparam int RATE_W      = 18;
    localparam int ACC_W       = RATE_W + 1;
    localparam int SAMPLE_W    = 16;
    localparam int AMP_W       = 8;
    localparam int CFG_DATA_W  = 18;
    localparam int CFG_INDEX_W = 2;

    localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

    localparam int SEARCH_STAGES = AMP_W;
    localparam int THR_DEPTH     = 1 << AMP_W;

    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef logic [RATE_W-1:0]     rate_t;
    typedef logic [ACC_W-1:0]      acc_t;
    typedef logic [SAMPLE_W-1:0]   sample_t;
    typedef logic [AMP_W-1:0]      amp_t;
    typedef logic [FIFO_PTR_W-1:0] fifo_ptr_t;
    typedef logic [FIFO_CNT_W-1:0] fifo_cnt_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_RATE   = 2'd0,
        REG_WIDE_SAMPLES = 2'd1,
        REG_STEREO       = 2'd2
    } cfg_reg_t;

    // Running extremes of one lane or of the merged window.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
    } lane_res_t;

    // What one frame asks of the amplitude stage.
    typedef struct packed {
        logic    close_en;
        logic    final_en;
        logic    zero_en;
        logic    final_last;
        logic    wide;
        sample_t d_close;
        sample_t d_final;
    } win_bundle_t;

    typedef struct packed {
        logic    close_en;
        logic    final_en;
        logic    zero_en;
        logic    final_last;
        logic    wide;
        sample_t d_close;
        sample_t d_final;
        amp_t    idx_close;
        amp_t    idx_final;
    } amp_stage_t;

    typedef struct packed {
        logic close_en;
        logic final_en;
        logic zero_en;
        logic final_last;
        amp_t amp_close;
        amp_t amp_final;
    } res_bundle_t;

    localparam real PI_VALUE = 3.14159265358979323846;

    typedef logic [SAMPLE_W-1:0] thr_tab_t [THR_DEPTH];

    // Entry k is the smallest difference whose amplitude code reaches k,
    // i.e. ceil(S * tan(k * pi / 1020)). The top entry equals S itself.
    function automatic thr_tab_t build_thr(input logic wide);
        thr_tab_t t;
        real      s;
        real      x;
        int       k;
        s = wide ? 32767.0 : 127.0;
        t[0] = '0;
        for (k = 1; k < THR_DEPTH - 1; k++) begin
            x = s * $tan(k * PI_VALUE / 1020.0);
            t[k] = SAMPLE_W'($rtoi($ceil(x)));
        end
        t[THR_DEPTH-1] = wide ? 16'd32767 : 16'd127;
        return t;
    endfunction

    localparam thr_tab_t THR_WIDE   = build_thr(1'b1);
    localparam thr_tab_t THR_NARROW = build_thr(1'b0);

endpackage

// File: design/ppe_lane.sv
// One channel lane: decodes a raw sample and folds it into the window extremes.
// Depends on ppe_pkg.
`timescale 1ns / 1ps

module ppe_lane
(
    input  ppe_pkg::sample_t   raw,
    input  logic               wide,
    input  ppe_pkg::lane_res_t base,
    input  logic               base_empty,
    output ppe_pkg::lane_res_t merged
);

    logic signed [ppe_pkg::SAMPLE_W-1:0] v;

    always_comb
    begin
        // Offset-128 bytes become two's complement by flipping the top bit.
        if (wide)
        begin
            v = $signed(raw);
        end
        else
        begin
            v = $signed({{8{~raw[7]}}, ~raw[7], raw[6:0]});
        end

        if (base_empty)
        begin
            merged.lo = v;
            merged.hi = v;
        end
        else
        begin
            merged.lo = (v < $signed(base.lo)) ? v : base.lo;
            merged.hi = (v > $signed(base.hi)) ? v : base.hi;
        end
    end

endmodule

// File: design/ppe_window.sv
// Window tracker: phase accumulator, window extremes and the merge of both lanes.
// Emits one request bundle per accepted frame. Depends on ppe_pkg and ppe_lane.
`timescale 1ns / 1ps

module ppe_window
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  ppe_pkg::sample_t     sample_first,
    input  ppe_pkg::sample_t     sample_second,
    input  logic                 last_frame,
    input  ppe_pkg::rate_t       frame_rate,
    input  logic                 wide_samples,
    input  logic                 stereo,
    output logic                 bundle_valid,
    output ppe_pkg::win_bundle_t bundle
);

    ppe_pkg::rate_t       phase_reg, phase_next;
    logic signed [ppe_pkg::SAMPLE_W-1:0] low_reg, low_next, high_reg, high_next;
    logic                 empty_reg, empty_next;
    logic                 seen_reg, seen_next;
    logic                 bundle_valid_reg;
    ppe_pkg::win_bundle_t bundle_reg, bundle_next;

    ppe_pkg::acc_t        acc, acc_wrap, acc_trail, rate_ext;
    ppe_pkg::rate_t       phase_step;
    logic                 closing, trailing, base_empty;
    ppe_pkg::lane_res_t   base, lane0, lane1, merged;

    ppe_lane u_lane0
    (
        .raw        (sample_first),
        .wide       (wide_samples),
        .base       (base),
        .base_empty (base_empty),
        .merged     (lane0)
    );

    ppe_lane u_lane1
    (
        .raw        (sample_second),
        .wide       (wide_samples),
        .base       (base),
        .base_empty (base_empty),
        .merged     (lane1)
    );

    always_comb
    begin
        rate_ext = {1'b0, frame_rate};
        acc      = {1'b0, phase_reg} + ppe_pkg::acc_t'(ppe_pkg::WINDOWS_PER_SECOND);
        closing  = seen_reg && (acc >= rate_ext);
        acc_wrap = acc - rate_ext;

        if (!seen_reg)
        begin
            phase_step = '0;
        end
        else if (closing)
        begin
            // A rate lowered under the phase wraps it to zero.
            phase_step = (acc_wrap >= rate_ext) ? '0 : acc_wrap[ppe_pkg::RATE_W-1:0];
        end
        else
        begin
            phase_step = acc[ppe_pkg::RATE_W-1:0];
        end

        base.lo    = low_reg;
        base.hi    = high_reg;
        base_empty = empty_reg || closing;

        // Merge stage: both lanes start from the same base, so the extremes combine.
        merged.lo = (stereo && ($signed(lane1.lo) < $signed(lane0.lo))) ? lane1.lo : lane0.lo;
        merged.hi = (stereo && ($signed(lane1.hi) > $signed(lane0.hi))) ? lane1.hi : lane0.hi;

        acc_trail = {1'b0, phase_step} + ppe_pkg::acc_t'(ppe_pkg::WINDOWS_PER_SECOND);
        trailing  = acc_trail >= rate_ext;

        bundle_next.close_en   = closing;
        bundle_next.final_en   = last_frame;
        bundle_next.zero_en    = last_frame && trailing;
        bundle_next.final_last = !trailing;
        bundle_next.wide       = wide_samples;
        bundle_next.d_close    = (!empty_reg && (high_reg > low_reg)) ?
                                 ppe_pkg::sample_t'(high_reg - low_reg) : '0;
        bundle_next.d_final    = ($signed(merged.hi) > $signed(merged.lo)) ?
                                 ppe_pkg::sample_t'(merged.hi - merged.lo) : '0;

        phase_next = phase_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        empty_next = empty_reg;
        seen_next  = seen_reg;
        if (accept)
        begin
            if (last_frame)
            begin
                phase_next = '0;
                low_next   = '0;
                high_next  = '0;
                empty_next = 1'b1;
                seen_next  = 1'b0;
            end
            else
            begin
                phase_next = phase_step;
                low_next   = merged.lo;
                high_next  = merged.hi;
                empty_next = 1'b0;
                seen_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= '0;
            low_reg          <= '0;
            high_reg         <= '0;
            empty_reg        <= 1'b1;
            seen_reg         <= 1'b0;
            bundle_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            low_reg          <= low_next;
            high_reg         <= high_next;
            empty_reg        <= empty_next;
            seen_reg         <= seen_next;
            bundle_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        bundle_reg <= bundle_next;
    end

    assign bundle_valid = bundle_valid_reg;
    assign bundle       = bundle_reg;

endmodule

// File: design/ppe_amp.sv
// Amplitude stage: binary search of the threshold tables, one bit per pipeline
// stage, for the closing and the final window side by side. Depends on ppe_pkg.
`timescale 1ns / 1ps

module ppe_amp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  ppe_pkg::win_bundle_t in_bundle,
    output logic                 out_valid,
    output ppe_pkg::res_bundle_t out_res
);

    ppe_pkg::amp_stage_t stage_reg  [ppe_pkg::SEARCH_STAGES];
    ppe_pkg::amp_stage_t stage_next [ppe_pkg::SEARCH_STAGES];
    logic [ppe_pkg::SEARCH_STAGES-1:0] valid_reg;
    ppe_pkg::amp_stage_t stage_in;

    function automatic ppe_pkg::amp_t search_step(input ppe_pkg::amp_t idx,
                                                  input ppe_pkg::sample_t d,
                                                  input logic wide,
                                                  input logic [2:0] bit_pos);
        ppe_pkg::amp_t    cand;
        ppe_pkg::sample_t thr;
        cand = idx | (ppe_pkg::amp_t'(1) << bit_pos);
        thr  = wide ? ppe_pkg::THR_WIDE[cand] : ppe_pkg::THR_NARROW[cand];
        return (thr <= d) ? cand : idx;
    endfunction

    always_comb
    begin
        stage_in.close_en   = in_bundle.close_en;
        stage_in.final_en   = in_bundle.final_en;
        stage_in.zero_en    = in_bundle.zero_en;
        stage_in.final_last = in_bundle.final_last;
        stage_in.wide       = in_bundle.wide;
        stage_in.d_close    = in_bundle.d_close;
        stage_in.d_final    = in_bundle.d_final;
        stage_in.idx_close  = '0;
        stage_in.idx_final  = '0;

        for (int j = 0; j < ppe_pkg::SEARCH_STAGES; j++)
        begin
            stage_next[j] = (j == 0) ? stage_in : stage_reg[(j == 0) ? 0 : j - 1];
            stage_next[j].idx_close = search_step(stage_next[j].idx_close,
                                                  stage_next[j].d_close, stage_next[j].wide,
                                                  3'(ppe_pkg::SEARCH_STAGES - 1 - j));
            stage_next[j].idx_final = search_step(stage_next[j].idx_final,
                                                  stage_next[j].d_final, stage_next[j].wide,
                                                  3'(ppe_pkg::SEARCH_STAGES - 1 - j));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[ppe_pkg::SEARCH_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < ppe_pkg::SEARCH_STAGES; j++)
        begin
            stage_reg[j] <= stage_next[j];
        end
    end

    assign out_valid          = valid_reg[ppe_pkg::SEARCH_STAGES-1];
    assign out_res.close_en   = stage_reg[ppe_pkg::SEARCH_STAGES-1].close_en;
    assign out_res.final_en   = stage_reg[ppe_pkg::SEARCH_STAGES-1].final_en;
    assign out_res.zero_en    = stage_reg[ppe_pkg::SEARCH_STAGES-1].zero_en;
    assign out_res.final_last = stage_reg[ppe_pkg::SEARCH_STAGES-1].final_last;
    assign out_res.amp_close  = stage_reg[ppe_pkg::SEARCH_STAGES-1].idx_close;
    assign out_res.amp_final  = stage_reg[ppe_pkg::SEARCH_STAGES-1].idx_final;

endmodule

// File: design/ppe_fifo.sv
// Result queue: holds per-frame result bundles, sends them out one result per
// transfer and keeps the credit count that throttles the input. Depends on ppe_pkg.
`timescale 1ns / 1ps
`include "pcm_peak_to_peak_envelope_unit_defines.svh"

module ppe_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  ppe_pkg::res_bundle_t in_res,
    input  logic                 issue,
    output logic                 can_accept,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output ppe_pkg::amp_t        m_tdata,
    output logic                 m_tlast
);

    ppe_pkg::res_bundle_t mem_reg [ppe_pkg::FIFO_DEPTH];
    ppe_pkg::fifo_ptr_t   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    ppe_pkg::fifo_cnt_t   count_reg, count_next, credit_reg, credit_next;
    logic [2:0]           done_reg, done_next;

    ppe_pkg::res_bundle_t head;
    logic [2:0]           head_en, pending, cur;
    logic                 push, drop, xfer, pop;

    always_comb
    begin
        head    = mem_reg[rd_ptr_reg];
        head_en = {head.zero_en, head.final_en, head.close_en};
        pending = head_en & ~done_reg;

        // Results leave in order: closing window, final window, trailing empty one.
        priority if (pending[0])
        begin
            cur     = 3'b001;
            m_tdata = head.amp_close;
            m_tlast = 1'b0;
        end
        else if (pending[1])
        begin
            cur     = 3'b010;
            m_tdata = head.amp_final;
            m_tlast = head.final_last;
        end
        else
        begin
            cur     = 3'b100;
            m_tdata = '0;
            m_tlast = 1'b1;
        end

        m_tvalid = (count_reg != '0);
        xfer     = m_tvalid && m_tready;
        pop      = xfer && ((pending & ~cur) == 3'b000);
        push     = in_valid && (in_res.close_en || in_res.final_en || in_res.zero_en);
        drop     = in_valid && !(in_res.close_en || in_res.final_en || in_res.zero_en);

        done_next = done_reg;
        if (pop)
        begin
            done_next = 3'b000;
        end
        else if (xfer)
        begin
            done_next = done_reg | cur;
        end

        wr_ptr_next = push ? wr_ptr_reg + ppe_pkg::fifo_ptr_t'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + ppe_pkg::fifo_ptr_t'(1) : rd_ptr_reg;
        count_next  = count_reg + ppe_pkg::fifo_cnt_t'(push) - ppe_pkg::fifo_cnt_t'(pop);
        // A frame holds its credit from acceptance until its bundle is gone.
        credit_next = credit_reg + ppe_pkg::fifo_cnt_t'(issue)
                      - ppe_pkg::fifo_cnt_t'(pop) - ppe_pkg::fifo_cnt_t'(drop);

        can_accept = credit_reg < ppe_pkg::fifo_cnt_t'(ppe_pkg::FIFO_DEPTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            credit_reg <= '0;
            done_reg   <= 3'b000;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            credit_reg <= credit_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_res;
        end
    end

    `PPE_ASSERT_ALWAYS(a_credit_bound, credit_reg <= ppe_pkg::fifo_cnt_t'(ppe_pkg::FIFO_DEPTH), "credit count above queue depth")
    `PPE_ASSERT_ALWAYS(a_count_in_credit, count_reg <= credit_reg, "queued bundles not covered by credits")
    `PPE_ASSERT_IMPLY(a_head_pending, m_tvalid, pending != 3'b000, "head bundle has no result left")

endmodule

// File: design/pcm_peak_to_peak_envelope_unit.sv
// PCM peak-to-peak envelope unit: top level with configuration registers.
// A frame's result passes the window bundle register, the amplitude search stages and
// the result queue before m_tvalid rises.
// Throughput: one frame per cycle while s_tready is high, results one per cycle while
// m_tready is high; up to sixteen frames in flight before s_tready drops (queue credits).
// Reset (rst_n, asynchronous, active low) empties the pipeline and restores the registers.
`timescale 1ns / 1ps

module pcm_peak_to_peak_envelope_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [ppe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ppe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,  // sample_first, sample_second
    input  logic                               s_tlast,  // last_frame
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,  // amplitude
    output logic                               m_tlast   // last_window
);

    ppe_pkg::rate_t       rate_reg;
    logic                 wide_reg;
    logic                 stereo_reg;

    logic                 accept;
    logic                 can_accept;
    logic                 bundle_valid;
    ppe_pkg::win_bundle_t bundle;
    logic                 res_valid;
    ppe_pkg::res_bundle_t res;

    assign s_tready = can_accept;
    assign accept   = s_tvalid && can_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= ppe_pkg::RATE_RESET;
            wide_reg   <= 1'b1;
            stereo_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ppe_pkg::REG_FRAME_RATE:
                begin
                    rate_reg <= (cfg_data < ppe_pkg::CFG_DATA_W'(ppe_pkg::MIN_RATE)) ?
                                ppe_pkg::rate_t'(ppe_pkg::MIN_RATE) : cfg_data;
                end
                ppe_pkg::REG_WIDE_SAMPLES:
                begin
                    wide_reg <= cfg_data[0];
                end
                ppe_pkg::REG_STEREO:
                begin
                    stereo_reg <= cfg_data[0];
                end
                default:
                begin
                    rate_reg <= rate_reg;
                end
            endcase
        end
    end

    ppe_window u_window
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .sample_first  (s_tdata[15:0]),
        .sample_second (s_tdata[31:16]),
        .last_frame    (s_tlast),
        .frame_rate    (rate_reg),
        .wide_samples  (wide_reg),
        .stereo        (stereo_reg),
        .bundle_valid  (bundle_valid),
        .bundle        (bundle)
    );

    ppe_amp u_amp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bundle_valid),
        .in_bundle (bundle),
        .out_valid (res_valid),
        .out_res   (res)
    );

    ppe_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (res_valid),
        .in_res     (res),
        .issue      (accept),
        .can_accept (can_accept),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// File: verif/pcm_peak_to_peak_envelope_unit_tb.sv
// Self-checking testbench for the PCM peak-to-peak envelope unit: streams frames through
// the block, predicts every window amplitude on its own and checks each result transfer.
// Depends on ppe_pkg and the pcm_peak_to_peak_envelope_unit RTL.
`timescale 1ns / 1ps

module pcm_peak_to_peak_envelope_unit_tb;

    typedef longint unsigned u64_t;

    typedef struct {
        ppe_pkg::sample_t first_sample;
        ppe_pkg::sample_t second_sample;
        logic             last_frame;
    } pcm_frame_t;

    typedef struct {
        ppe_pkg::amp_t amplitude;
        logic          last_window;
    } window_result_t;

    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [ppe_pkg::CFG_INDEX_W-1:0] cfg_index = ppe_pkg::REG_FRAME_RATE;
    logic [ppe_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [31:0]                     s_tdata = '0;  // sample_first, sample_second
    logic                            s_tlast = 1'b0;  // last_frame
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [7:0]                      m_tdata;  // amplitude
    logic                            m_tlast;  // last_window

    pcm_frame_t     pending_frames[$];
    window_result_t expected_envelope[$];
    int             failures = 0;
    bit             calm = 1'b0;
    bit             hold_request = 1'b0;
    int             hold_left = 0;

    // Shadow of the configuration registers and of the window tracking state.
    int unsigned rate_shadow = ppe_pkg::RATE_RESET;
    bit          wide_shadow = 1'b1;
    bit          stereo_shadow = 1'b0;
    int          win_low = 0;
    int          win_high = 0;
    bit          win_empty = 1'b1;
    int unsigned phase_acc = 0;
    bit          stream_open = 1'b0;

    pcm_peak_to_peak_envelope_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Arctangent of p/q in Q46 from its power series; p < q.
    function automatic u64_t arctan_q46(input u64_t p, input u64_t q);
        u64_t pw;
        u64_t sum;
        u64_t term;
        pw = (p << 46) / q;
        sum = 0;
        for (int n = 0; n < 40 && pw != 0; n++)
        begin
            term = pw / u64_t'(2 * n + 1);
            if (n % 2 == 0)
                sum += term;
            else
                sum -= term;
            pw = pw * p / q;
            pw = pw * p / q;
        end
        return sum;
    endfunction

    function automatic ppe_pkg::amp_t amplitude_code(input int lo, input int hi,
                                                     input bit empty);
        u64_t full_scale;
        u64_t diff;
        u64_t quarter;
        u64_t angle;
        u64_t code;
        full_scale = wide_shadow ? 32767 : 127;
        if (empty || hi <= lo)
            return '0;
        diff = u64_t'(hi - lo);
        if (diff >= full_scale)
            return 8'd255;
        quarter = 4 * arctan_q46(1, 5) - arctan_q46(1, 239);
        // Near full scale the series converges slowly, so use the complementary angle.
        if (5 * diff > 2 * full_scale)
            angle = quarter - arctan_q46(full_scale - diff, full_scale + diff);
        else
            angle = arctan_q46(diff, full_scale);
        code = 255 * angle / quarter;
        return (code > 255) ? 8'd255 : ppe_pkg::amp_t'(code);
    endfunction

    task automatic join_sample(input ppe_pkg::sample_t raw);
        int value;
        value = wide_shadow ? int'($signed(raw)) : int'(raw[7:0]) - 128;
        if (win_empty)
        begin
            win_low = value;
            win_high = value;
            win_empty = 1'b0;
        end
        else
        begin
            if (value < win_low)
                win_low = value;
            if (value > win_high)
                win_high = value;
        end
    endtask

    task automatic push_window(input ppe_pkg::amp_t amplitude, input logic last_window);
        window_result_t res;
        res.amplitude = amplitude;
        res.last_window = last_window;
        expected_envelope.push_back(res);
    endtask

    task automatic predict_envelope(input pcm_frame_t frame);
        int unsigned next_phase;
        bit          trailing;
        if (stream_open)
        begin
            next_phase = phase_acc + ppe_pkg::WINDOWS_PER_SECOND;
            if (next_phase >= rate_shadow)
            begin
                next_phase -= rate_shadow;
                // A rate lowered under the running phase restarts it.
                if (next_phase >= rate_shadow)
                    next_phase = 0;
                push_window(amplitude_code(win_low, win_high, win_empty), 1'b0);
                win_low = 0;
                win_high = 0;
                win_empty = 1'b1;
            end
            phase_acc = next_phase;
        end
        else
        begin
            stream_open = 1'b1;
            phase_acc = 0;
        end
        join_sample(frame.first_sample);
        if (stereo_shadow)
            join_sample(frame.second_sample);
        if (frame.last_frame)
        begin
            trailing = (phase_acc + ppe_pkg::WINDOWS_PER_SECOND >= rate_shadow);
            push_window(amplitude_code(win_low, win_high, win_empty), !trailing);
            if (trailing)
                push_window('0, 1'b1);
            win_low = 0;
            win_high = 0;
            win_empty = 1'b1;
            phase_acc = 0;
            stream_open = 1'b0;
        end
    endtask

    // Sender: offers the next queued frame once the current one has been taken.
    always @(posedge clk or negedge rst_n)
    begin : frame_driver
        pcm_frame_t frame;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_frames.size() != 0 && (calm || $urandom_range(0, 99) >= 29))
            begin
                frame = pending_frames.pop_front();
                s_tdata <= {frame.second_sample, frame.first_sample};
                s_tlast <= frame.last_frame;
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : frame_monitor
        pcm_frame_t frame;
        if (rst_n && s_tvalid && s_tready)
        begin
            frame.first_sample = s_tdata[15:0];
            frame.second_sample = s_tdata[31:16];
            frame.last_frame = s_tlast;
            predict_envelope(frame);
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= calm || ($urandom_range(0, 99) >= 29);
        end
    end

    always @(posedge clk)
    begin : result_checker
        window_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_envelope.size() == 0)
            begin
                $display("%0t: unexpected result transfer, amplitude %0d last %0b",
                         $time, m_tdata, m_tlast);
                failures++;
            end
            else
            begin
                want = expected_envelope.pop_front();
                if (m_tdata !== want.amplitude)
                begin
                    $display("%0t: amplitude expected %0d actual %0d",
                             $time, want.amplitude, m_tdata);
                    failures++;
                end
                if (m_tlast !== want.last_window)
                begin
                    $display("%0t: last_window expected %0b actual %0b",
                             $time, want.last_window, m_tlast);
                    failures++;
                end
            end
        end
    end

    task automatic queue_frame(input ppe_pkg::sample_t first, input ppe_pkg::sample_t second,
                               input logic last);
        pcm_frame_t frame;
        frame.first_sample = first;
        frame.second_sample = second;
        frame.last_frame = last;
        pending_frames.push_back(frame);
    endtask

    // Waits until every frame is taken and every result has arrived, then lets the
    // pipeline settle, since a frame may still be in flight without causing a result.
    task automatic drain_all();
        do
            @(negedge clk);
        while (pending_frames.size() != 0 || s_tvalid || expected_envelope.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input ppe_pkg::cfg_reg_t idx, input int unsigned value);
        int unsigned masked;
        masked = value & ((1 << ppe_pkg::RATE_W) - 1);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= ppe_pkg::CFG_DATA_W'(value);
        case (idx)
            ppe_pkg::REG_FRAME_RATE:
                rate_shadow = (masked < ppe_pkg::MIN_RATE) ? ppe_pkg::MIN_RATE : masked;
            ppe_pkg::REG_WIDE_SAMPLES: wide_shadow = value[0];
            ppe_pkg::REG_STEREO:       stereo_shadow = value[0];
            default:                   ;
        endcase
    endtask

    task automatic configure(input int unsigned rate, input bit wide, input bit two_channels);
        write_reg(ppe_pkg::REG_FRAME_RATE, rate);
        write_reg(ppe_pkg::REG_WIDE_SAMPLES, wide);
        write_reg(ppe_pkg::REG_STEREO, two_channels);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly short windows so results come often; now and then the extremes.
    function automatic int unsigned pick_rate();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, ppe_pkg::MIN_RATE - 1);
            1:       return 192000;
            2:       return (1 << ppe_pkg::RATE_W) - 1;
            3:       return $urandom_range(ppe_pkg::MIN_RATE, 3000);
            default: return $urandom_range(ppe_pkg::MIN_RATE, 300);
        endcase
    endfunction

    // Samples scattered around a center with a random spread, so amplitudes cover
    // the whole code range instead of saturating.
    function automatic ppe_pkg::sample_t noisy_sample(input ppe_pkg::sample_t center);
        int unsigned span;
        if ($urandom_range(0, 3) == 0)
            return ppe_pkg::sample_t'($urandom);
        span = 1 << $urandom_range(0, 15);
        return center + ppe_pkg::sample_t'($urandom_range(0, span))
               - ppe_pkg::sample_t'(span >> 1);
    endfunction

    task automatic random_frames(input int count);
        ppe_pkg::sample_t center;
        logic             last;
        center = ppe_pkg::sample_t'($urandom);
        for (int i = 0; i < count; i++)
        begin
            last = ($urandom_range(0, 9) == 0);
            queue_frame(noisy_sample(center), noisy_sample(center), last);
            if (last)
                center = ppe_pkg::sample_t'($urandom);
        end
    endtask

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: full-scale swing, then a one-frame stream with no swing.
        queue_frame(16'h8000, 16'h0000, 1'b0);
        queue_frame(16'h7FFF, 16'hFFFF, 1'b0);
        queue_frame(16'h0000, 16'hFFFF, 1'b1);
        queue_frame(16'hFFFF, 16'hFFFF, 1'b1);
        drain_all();

        // A rate write of zero clamps to the minimum: every frame closes a window.
        configure(0, 1'b1, 1'b1);
        queue_frame(16'h0000, 16'h0001, 1'b0);
        queue_frame(16'h0000, 16'h7FFE, 1'b0);
        queue_frame(16'h0000, 16'd13106, 1'b0);
        queue_frame(16'h0000, 16'd13107, 1'b0);
        queue_frame(16'hFFFF, 16'h7FFE, 1'b0);
        queue_frame(16'h8000, 16'h7FFF, 1'b1);
        drain_all();

        // Offset-128 samples; only the low byte counts.
        configure(ppe_pkg::MIN_RATE, 1'b0, 1'b1);
        queue_frame(16'h0080, 16'hFF80, 1'b0);
        queue_frame(16'h0000, 16'h00FF, 1'b0);
        queue_frame(16'h0001, 16'h007F, 1'b0);
        queue_frame(16'h1200, 16'h347F, 1'b0);
        queue_frame(16'h0000, 16'h0032, 1'b0);
        queue_frame(16'h0000, 16'h0033, 1'b0);
        queue_frame(16'h0040, 16'h0041, 1'b1);
        drain_all();

        // Leave a window open at a slow rate, then switch mode and drop the rate
        // under the running phase before the stream goes on.
        configure(192000, 1'b1, 1'b0);
        queue_frame(16'h1000, 16'h0000, 1'b0);
        queue_frame(16'hF000, 16'h0000, 1'b0);
        queue_frame(16'h0123, 16'h0000, 1'b0);
        drain_all();
        configure(ppe_pkg::MIN_RATE, 1'b0, 1'b0);
        queue_frame(16'h0080, 16'h0000, 1'b0);
        queue_frame(16'h0090, 16'h0000, 1'b1);
        drain_all();

        for (int phase = 0; phase < 11; phase++)
        begin
            if (phase == 6)
            begin
                // Stall the output while frames keep coming, so the input backs up.
                configure(ppe_pkg::MIN_RATE, 1'b1, 1'b1);
                calm = 1'b1;
                hold_request = 1'b1;
                random_frames(40);
            end
            else
            begin
                configure(pick_rate(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                calm = (phase == 3);
                random_frames(29);
            end
            drain_all();
            calm = 1'b0;
        end

        if (failures == 0 && expected_envelope.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
